### hw/rtl/sfd_pkg.sv
// sfd_pkg: shared types and constants of the stereo feedback delay.
// Control-register indexes, gain limits, sequencer states and lane control.
// No dependencies.
package sfd_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int DELAY_W    = 17;
   localparam int GAIN_W     = 17;
   localparam int FB_W       = 15;
   localparam int Q15_HALF   = 16384;

   localparam logic [CSR_IDX_W-1:0] CSR_WET_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_GAIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMP_ALPHA = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MONO       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BYPASS     = 3'd5;

   localparam logic [GAIN_W-1:0] Q15_ONE = 17'd32768;
   localparam logic [FB_W-1:0]   FB_MAX  = 15'd31130;

   localparam logic [15:0]        WET_RST   = 16'd16384;
   localparam logic [FB_W-1:0]    FB_RST    = 15'd16384;
   localparam logic [DELAY_W-1:0] DELAY_RST = 17'd12000;
   localparam logic [15:0]        ALPHA_RST = 16'd32768;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_DAMP = 5'b00010,
      S_UPD  = 5'b00100,
      S_MUL  = 5'b01000,
      S_WB   = 5'b10000
   } sfd_state_type;

   typedef struct packed {
      logic ld_in;
      logic ld_p1;
      logic ld_damp;
      logic ld_mul;
      logic byp;
   } sfd_lane_ctl_type;

endpackage

### hw/rtl/sfd_ifs.sv
// sfd_ifs: valid/ready stream interfaces for request and response words.
// Payload width follows the sample width. No dependencies.
interface sfd_req_if #(parameter int SAMPLE_BITS = 16) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_in;
   logic signed [SAMPLE_BITS-1:0] right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sfd_rsp_if #(parameter int SAMPLE_BITS = 16) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

### hw/rtl/sfd_ram.sv
// sfd_ram: generic single-clock RAM, one write port, one registered read port.
// No dependencies.
module sfd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/sfd_lane.sv
// sfd_lane: one channel's datapath: damping filter, feedback write word, wet/dry mix.
// Depends on sfd_pkg; sequenced by the top level.
module sfd_lane import sfd_pkg::*; #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sfd_lane_ctl_type              ctl,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [SAMPLE_BITS-1:0] tap,
   input  logic                          tap_ok,
   input  logic [GAIN_W-1:0]             alpha,
   input  logic [FB_W-1:0]               fb,
   input  logic [GAIN_W-1:0]             wet,
   output logic signed [SAMPLE_BITS-1:0] wr_data,
   output logic signed [SAMPLE_BITS-1:0] out_sample
);

   localparam int SB = SAMPLE_BITS;
   localparam int WW = SB + 20;
   localparam logic signed [WW-1:0] SMAX = {{(WW-SB+1){1'b0}}, {(SB-1){1'b1}}};
   localparam logic signed [WW-1:0] SMIN = {{(WW-SB+1){1'b1}}, {(SB-1){1'b0}}};

   function automatic logic signed [WW-1:0] rnd15(input logic signed [WW-1:0] p);
      logic signed [WW-1:0] v;
      v = p + $signed(WW'(Q15_HALF));
      return v >>> 15;
   endfunction

   function automatic logic signed [SB-1:0] sat(input logic signed [WW-1:0] v);
      logic signed [WW-1:0] c;
      c = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
      return c[SB-1:0];
   endfunction

   logic signed [SB-1:0]   x_ff, x_in;
   logic signed [SB-1:0]   damp_ff, damp_in;
   logic signed [SB+18:0]  p1_ff, p1_in;
   logic signed [SB+15:0]  pf_ff, pf_in;
   logic signed [SB+17:0]  pw_ff, pw_in;
   logic signed [SB+17:0]  pd_ff, pd_in;

   logic signed [SB-1:0]   tap_eff;
   logic signed [SB:0]     diff;
   logic signed [17:0]     alpha_s;
   logic signed [15:0]     fb_s;
   logic signed [17:0]     wet_s;
   logic signed [17:0]     dry_s;
   logic signed [SB-1:0]   mix;

   always_comb begin
      tap_eff = tap_ok ? tap : '0;
      diff    = $signed({tap_eff[SB-1], tap_eff}) - $signed({damp_ff[SB-1], damp_ff});
      alpha_s = $signed({1'b0, alpha});
      fb_s    = $signed({1'b0, fb});
      wet_s   = $signed({1'b0, wet});
      dry_s   = $signed({1'b0, Q15_ONE - wet});

      x_in    = ctl.ld_in   ? sample : x_ff;
      p1_in   = ctl.ld_p1   ? diff * alpha_s : p1_ff;
      damp_in = ctl.ld_damp ? sat(WW'(damp_ff) + rnd15(WW'(p1_ff))) : damp_ff;
      pf_in   = ctl.ld_mul  ? damp_ff * fb_s  : pf_ff;
      pw_in   = ctl.ld_mul  ? damp_ff * wet_s : pw_ff;
      pd_in   = ctl.ld_mul  ? x_ff * dry_s    : pd_ff;

      wr_data    = sat(WW'(x_ff) + rnd15(WW'(pf_ff)));
      mix        = sat(rnd15(WW'(pw_ff) + WW'(pd_ff)));
      out_sample = ctl.byp ? x_ff : mix;
   end

   always_ff @(posedge clock) begin
      x_ff  <= x_in;
      p1_ff <= p1_in;
      pf_ff <= pf_in;
      pw_ff <= pw_in;
      pd_ff <= pd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         damp_ff <= '0;
      end else begin
         damp_ff <= damp_in;
      end
   end

endmodule

### hw/rtl/stereo_feedback_delay_damped_unit.sv
// stereo_feedback_delay_damped_unit: stereo feedback delay with damped tap, top level.
// A word taken in idle runs damp, update, multiply and write-back states (bypass skips to
// write-back), around the single shared ring RAM; the result is registered at write-back.
// No new word is taken until back in idle; a held result stalls only the write-back.
// Reset: synchronous; registers to defaults, filter state and write index zeroed; ring
// entries not yet written since reset read as zero via the write index and a wrap flag.
module stereo_feedback_delay_damped_unit import sfd_pkg::*; #(
   parameter int RING_DEPTH  = 131072,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   sfd_req_if.sink               req_bus,
   sfd_rsp_if.source             rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int SB = SAMPLE_BITS;
   localparam int AW = $clog2(RING_DEPTH);
   localparam int CW = ((AW > DELAY_W) ? AW : DELAY_W) + 1;
   localparam logic [CW-1:0] DMAX     = CW'(RING_DEPTH - 1);
   localparam logic [AW-1:0] IDX_LAST = AW'(RING_DEPTH - 1);
   localparam logic [AW:0]   DEPTH_X  = (AW+1)'(RING_DEPTH);

   // control registers
   logic [15:0]        wet_ff, wet_in;
   logic [FB_W-1:0]    fb_ff, fb_in;
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [15:0]        alpha_ff, alpha_in;
   logic               mono_ff, mono_in;
   logic               bypass_ff, bypass_in;

   // sequencer and ring bookkeeping
   sfd_state_type      state_ff, state_in;
   logic [AW-1:0]      wr_idx_ff, wr_idx_in;
   logic               wrap_ff, wrap_in;
   logic               byp_ff, byp_in;
   logic               rd_ok_ff, rd_ok_in;

   // result word
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0] rsp_left_ff, rsp_left_in;
   logic signed [SB-1:0] rsp_right_ff, rsp_right_in;

   logic               req_fire;
   logic               out_free;
   logic               out_load;
   logic               ram_we;
   sfd_lane_ctl_type   lane_ctl;

   logic [GAIN_W-1:0]  wet_c, alpha_c;
   logic [FB_W-1:0]    fb_c;
   logic [CW-1:0]      dly_w, dly_c;
   logic [AW-1:0]      dly_a;
   logic [AW:0]        rd_sum;
   logic [AW-1:0]      rd_addr;

   logic signed [SB-1:0] right_sel;
   logic [2*SB-1:0]    ram_rd;
   logic [2*SB-1:0]    ram_wd;
   logic signed [SB-1:0] wr_l, wr_r, out_l, out_r;

   // gain and delay limits
   always_comb begin
      wet_c   = ({1'b0, wet_ff} > Q15_ONE) ? Q15_ONE : {1'b0, wet_ff};
      alpha_c = ({1'b0, alpha_ff} > Q15_ONE) ? Q15_ONE : {1'b0, alpha_ff};
      fb_c    = (fb_ff > FB_MAX) ? FB_MAX : fb_ff;
      dly_w   = CW'(delay_ff);
      if (delay_ff == '0) begin
         dly_c = CW'(1);
      end else if (dly_w > DMAX) begin
         dly_c = DMAX;
      end else begin
         dly_c = dly_w;
      end
      dly_a = dly_c[AW-1:0];
      if (wr_idx_ff >= dly_a) begin
         rd_sum = {1'b0, wr_idx_ff} - {1'b0, dly_a};
      end else begin
         rd_sum = {1'b0, wr_idx_ff} + DEPTH_X - {1'b0, dly_a};
      end
      rd_addr = rd_sum[AW-1:0];
   end

   // control register writes
   always_comb begin
      wet_in    = wet_ff;
      fb_in     = fb_ff;
      delay_in  = delay_ff;
      alpha_in  = alpha_ff;
      mono_in   = mono_ff;
      bypass_in = bypass_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_WET_GAIN:   wet_in    = csr_wr_data[15:0];
            CSR_FB_GAIN:    fb_in     = csr_wr_data[FB_W-1:0];
            CSR_DELAY:      delay_in  = csr_wr_data[DELAY_W-1:0];
            CSR_DAMP_ALPHA: alpha_in  = csr_wr_data[15:0];
            CSR_MONO:       mono_in   = csr_wr_data[0];
            CSR_BYPASS:     bypass_in = csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      req_bus.ready = (state_ff == S_IDLE);
      req_fire      = req_bus.valid && req_bus.ready;
      out_free      = !rsp_valid_ff || rsp_bus.ready;
      out_load      = (state_ff == S_WB) && out_free;
      ram_we        = out_load && !byp_ff;

      state_in = state_ff;
      byp_in   = byp_ff;
      rd_ok_in = rd_ok_ff;
      lane_ctl = '0;
      lane_ctl.byp = byp_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               lane_ctl.ld_in = 1'b1;
               byp_in   = bypass_ff;
               rd_ok_in = wrap_ff || (rd_addr < wr_idx_ff);
               state_in = bypass_ff ? S_WB : S_DAMP;
            end
         end
         S_DAMP: begin
            lane_ctl.ld_p1 = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            lane_ctl.ld_damp = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            lane_ctl.ld_mul = 1'b1;
            state_in = S_WB;
         end
         S_WB: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      wr_idx_in = wr_idx_ff;
      wrap_in   = wrap_ff;
      if (ram_we) begin
         if (wr_idx_ff == IDX_LAST) begin
            wr_idx_in = '0;
            wrap_in   = 1'b1;
         end else begin
            wr_idx_in = wr_idx_ff + AW'(1);
         end
      end

      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_bus.ready);
      rsp_left_in  = out_load ? out_l : rsp_left_ff;
      rsp_right_in = out_load ? out_r : rsp_right_ff;
   end

   assign right_sel = (mono_ff && !bypass_ff) ? req_bus.left_in : req_bus.right_in;
   assign ram_wd    = {wr_l, wr_r};

   sfd_ram #(
      .WIDTH (2*SB),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx_ff),
      .wr_data (ram_wd),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   sfd_lane #(.SAMPLE_BITS(SB)) u_lane_l (
      .clock      (clock),
      .reset      (reset),
      .ctl        (lane_ctl),
      .sample     (req_bus.left_in),
      .tap        ($signed(ram_rd[2*SB-1:SB])),
      .tap_ok     (rd_ok_ff),
      .alpha      (alpha_c),
      .fb         (fb_c),
      .wet        (wet_c),
      .wr_data    (wr_l),
      .out_sample (out_l)
   );

   sfd_lane #(.SAMPLE_BITS(SB)) u_lane_r (
      .clock      (clock),
      .reset      (reset),
      .ctl        (lane_ctl),
      .sample     (right_sel),
      .tap        ($signed(ram_rd[SB-1:0])),
      .tap_ok     (rd_ok_ff),
      .alpha      (alpha_c),
      .fb         (fb_c),
      .wet        (wet_c),
      .wr_data    (wr_r),
      .out_sample (out_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wet_ff       <= WET_RST;
         fb_ff        <= FB_RST;
         delay_ff     <= DELAY_RST;
         alpha_ff     <= ALPHA_RST;
         mono_ff      <= 1'b0;
         bypass_ff    <= 1'b0;
         state_ff     <= S_IDLE;
         wr_idx_ff    <= '0;
         wrap_ff      <= 1'b0;
         byp_ff       <= 1'b0;
         rd_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wet_ff       <= wet_in;
         fb_ff        <= fb_in;
         delay_ff     <= delay_in;
         alpha_ff     <= alpha_in;
         mono_ff      <= mono_in;
         bypass_ff    <= bypass_in;
         state_ff     <= state_in;
         wr_idx_ff    <= wr_idx_in;
         wrap_ff      <= wrap_in;
         byp_ff       <= byp_in;
         rd_ok_ff     <= rd_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.left_out  = rsp_left_ff;
   assign rsp_bus.right_out = rsp_right_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("sequencer idle right after taking a word");

   a_idx_moves_on_wb: assert property (@(posedge clock)
      (!reset && !$past(reset) && !$stable(wr_idx_ff)) |-> $past(ram_we))
      else $error("write index moved without a ring write-back");

   a_wrap_sticky: assert property (@(posedge clock)
      (!reset && !$past(reset)) |-> !$fell(wrap_ff))
      else $error("ring wrap flag cleared outside reset");

   a_bypass_keeps_idx: assert property (@(posedge clock) disable iff (reset)
      (out_load && byp_ff) |=> $stable(wr_idx_ff))
      else $error("bypass word disturbed the write index");
`endif

endmodule
